// ----- rtl/flsm_pkg.sv -----
// Package: shared types, command codes and the sequencer's control store.
package flsm_pkg;

    localparam int SECTORS_DEF = 2;
    localparam int UNITS_PER_SECTOR_DEF = 16;

    // Input opcodes carried in s_tuser
    localparam logic [1:0] OP_SCAN      = 2'd0;
    localparam logic [1:0] OP_SAVE      = 2'd1;
    localparam logic [1:0] OP_ERASE_ALL = 2'd2;

    typedef enum logic [2:0] {
        CMD_LOADED       = 3'd0,
        CMD_ERASE_ALL    = 3'd1,
        CMD_ERASE_SECTOR = 3'd2,
        CMD_PROGRAM      = 3'd3,
        CMD_ZERO_CLEAR   = 3'd4,
        CMD_NO_CHANGE    = 3'd5
    } cmd_t;

    typedef enum logic [3:0] {
        U_NOP,
        U_FETCH,
        U_SCAN_UPD,
        U_LOC_INIT,
        U_LOC_STEP,
        U_LOC_DONE,
        U_CLR_FOUND,
        U_T_NEXT,
        U_TINC,
        U_A_FROM_T,
        U_A_CLR,
        U_SWEEP,
        U_WR_T0,
        U_WR_CUR0,
        U_CUR_FROM_T,
        U_CUR_LAST
    } uop_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_OP_SCAN,
        C_OP_SAVE,
        C_OP_ERASE,
        C_NOT_TOOK,
        C_NOT_LAST,
        C_NOT_FOUND,
        C_SAME,
        C_HIT,
        C_ERASED,
        C_T_NE_CUR,
        C_A_NE_END,
        C_A_NE_SECEND,
        C_BOOT,
        C_EMIT
    } cond_t;

    typedef enum logic [1:0] {
        SRC_T,
        SRC_CUR,
        SRC_ZERO
    } src_t;

    typedef logic [4:0] pc_t;

    // Program labels
    localparam pc_t P_FETCH      = 5'd0;
    localparam pc_t P_DEC_SCAN   = 5'd1;
    localparam pc_t P_DEC_SAVE   = 5'd2;
    localparam pc_t P_DEC_ERASE  = 5'd3;
    localparam pc_t P_DEC_OTHER  = 5'd4;
    localparam pc_t P_SCAN       = 5'd5;
    localparam pc_t P_SCAN_CHK   = 5'd6;
    localparam pc_t P_LOC_INIT   = 5'd7;
    localparam pc_t P_LOC        = 5'd8;
    localparam pc_t P_LOC_DONE   = 5'd9;
    localparam pc_t P_SCAN_END   = 5'd10;
    localparam pc_t P_SCAN_FND   = 5'd11;
    localparam pc_t P_LOADED     = 5'd12;
    localparam pc_t P_SAVE       = 5'd13;
    localparam pc_t P_SRCH_INIT  = 5'd14;
    localparam pc_t P_SRCH       = 5'd15;
    localparam pc_t P_SRCH_TEST  = 5'd16;
    localparam pc_t P_SRCH_NEXT  = 5'd17;
    localparam pc_t P_FOUND      = 5'd18;
    localparam pc_t P_ERASE_SEC  = 5'd19;
    localparam pc_t P_SWS_INIT   = 5'd20;
    localparam pc_t P_SWS        = 5'd21;
    localparam pc_t P_PROG       = 5'd22;
    localparam pc_t P_PROG_EMIT  = 5'd23;
    localparam pc_t P_ZCLR       = 5'd24;
    localparam pc_t P_ZCLR_EMIT  = 5'd25;
    localparam pc_t P_ADVANCE    = 5'd26;
    localparam pc_t P_NOCHG      = 5'd27;
    localparam pc_t P_ERASE      = 5'd28;
    localparam pc_t P_SWA        = 5'd29;
    localparam pc_t P_ERASE_DONE = 5'd30;
    localparam pc_t P_ERASE_EMIT = 5'd31;

    typedef struct packed {
        uop_t  uop;
        logic  emit;
        cond_t cond;
        pc_t   target;
        cmd_t  cmd;
        src_t  src;
        logic  last;
    } ucode_t;

    typedef struct packed {
        logic stall;
        logic op_scan;
        logic op_save;
        logic op_erase;
        logic not_took;
        logic not_last;
        logic not_found;
        logic same;
        logic hit;
        logic erased;
        logic t_ne_cur;
        logic a_ne_end;
        logic a_ne_secend;
        logic boot;
    } stat_t;

    function automatic ucode_t mk(uop_t uop, cond_t cond, pc_t target);
        ucode_t uc;
        uc.uop    = uop;
        uc.emit   = 1'b0;
        uc.cond   = cond;
        uc.target = target;
        uc.cmd    = CMD_LOADED;
        uc.src    = SRC_ZERO;
        uc.last   = 1'b0;
        return uc;
    endfunction

    function automatic ucode_t mk_emit(cmd_t cmd, src_t src, logic last, cond_t cond,
                                       pc_t target);
        ucode_t uc;
        uc.uop    = U_NOP;
        uc.emit   = 1'b1;
        uc.cond   = cond;
        uc.target = target;
        uc.cmd    = cmd;
        uc.src    = src;
        uc.last   = last;
        return uc;
    endfunction

    function automatic ucode_t rom(pc_t pc);
        ucode_t uc;
        unique case (pc)
            P_FETCH:      uc = mk(U_FETCH, C_NEVER, P_FETCH);
            P_DEC_SCAN:   uc = mk(U_NOP, C_OP_SCAN, P_SCAN);
            P_DEC_SAVE:   uc = mk(U_NOP, C_OP_SAVE, P_SAVE);
            P_DEC_ERASE:  uc = mk(U_NOP, C_OP_ERASE, P_ERASE);
            P_DEC_OTHER:  uc = mk(U_NOP, C_ALWAYS, P_FETCH);
            P_SCAN:       uc = mk(U_SCAN_UPD, C_NEVER, P_FETCH);
            P_SCAN_CHK:   uc = mk(U_NOP, C_NOT_TOOK, P_SCAN_END);
            P_LOC_INIT:   uc = mk(U_LOC_INIT, C_NEVER, P_FETCH);
            P_LOC:        uc = mk(U_LOC_STEP, C_T_NE_CUR, P_LOC);
            P_LOC_DONE:   uc = mk(U_LOC_DONE, C_NEVER, P_FETCH);
            P_SCAN_END:   uc = mk(U_NOP, C_NOT_LAST, P_FETCH);
            P_SCAN_FND:   uc = mk(U_CLR_FOUND, C_NOT_FOUND, P_ERASE);
            P_LOADED:     uc = mk_emit(CMD_LOADED, SRC_CUR, 1'b1, C_ALWAYS, P_FETCH);
            P_SAVE:       uc = mk(U_NOP, C_SAME, P_NOCHG);
            P_SRCH_INIT:  uc = mk(U_T_NEXT, C_NEVER, P_FETCH);
            P_SRCH:       uc = mk(U_NOP, C_NEVER, P_FETCH);
            P_SRCH_TEST:  uc = mk(U_NOP, C_HIT, P_FOUND);
            P_SRCH_NEXT:  uc = mk(U_TINC, C_ALWAYS, P_SRCH);
            P_FOUND:      uc = mk(U_NOP, C_ERASED, P_PROG);
            P_ERASE_SEC:  uc = mk_emit(CMD_ERASE_SECTOR, SRC_T, 1'b0, C_NEVER, P_FETCH);
            P_SWS_INIT:   uc = mk(U_A_FROM_T, C_NEVER, P_FETCH);
            P_SWS:        uc = mk(U_SWEEP, C_A_NE_SECEND, P_SWS);
            P_PROG:       uc = mk(U_WR_T0, C_NEVER, P_FETCH);
            P_PROG_EMIT:  uc = mk_emit(CMD_PROGRAM, SRC_T, 1'b0, C_NEVER, P_FETCH);
            P_ZCLR:       uc = mk(U_WR_CUR0, C_NEVER, P_FETCH);
            P_ZCLR_EMIT:  uc = mk_emit(CMD_ZERO_CLEAR, SRC_CUR, 1'b1, C_NEVER, P_FETCH);
            P_ADVANCE:    uc = mk(U_CUR_FROM_T, C_ALWAYS, P_FETCH);
            P_NOCHG:      uc = mk_emit(CMD_NO_CHANGE, SRC_CUR, 1'b1, C_ALWAYS, P_FETCH);
            P_ERASE:      uc = mk(U_A_CLR, C_NEVER, P_FETCH);
            P_SWA:        uc = mk(U_SWEEP, C_A_NE_END, P_SWA);
            P_ERASE_DONE: uc = mk(U_CUR_LAST, C_BOOT, P_FETCH);
            P_ERASE_EMIT: uc = mk_emit(CMD_ERASE_ALL, SRC_ZERO, 1'b1, C_ALWAYS, P_FETCH);
            default:      uc = mk(U_NOP, C_ALWAYS, P_FETCH);
        endcase
        return uc;
    endfunction

endpackage

// ----- rtl/flsm_sequencer.sv -----
// Sequencer: step counter, control store lookup and conditional jumps.
module flsm_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  flsm_pkg::stat_t stat,
    output flsm_pkg::ucode_t ucode
);

    flsm_pkg::pc_t pc_reg;
    flsm_pkg::pc_t pc_next;
    logic          take;

    assign ucode = flsm_pkg::rom(pc_reg);

    always_comb
    begin
        unique case (ucode.cond)
            flsm_pkg::C_NEVER:       take = 1'b0;
            flsm_pkg::C_ALWAYS:      take = 1'b1;
            flsm_pkg::C_OP_SCAN:     take = stat.op_scan;
            flsm_pkg::C_OP_SAVE:     take = stat.op_save;
            flsm_pkg::C_OP_ERASE:    take = stat.op_erase;
            flsm_pkg::C_NOT_TOOK:    take = stat.not_took;
            flsm_pkg::C_NOT_LAST:    take = stat.not_last;
            flsm_pkg::C_NOT_FOUND:   take = stat.not_found;
            flsm_pkg::C_SAME:        take = stat.same;
            flsm_pkg::C_HIT:         take = stat.hit;
            flsm_pkg::C_ERASED:      take = stat.erased;
            flsm_pkg::C_T_NE_CUR:    take = stat.t_ne_cur;
            flsm_pkg::C_A_NE_END:    take = stat.a_ne_end;
            flsm_pkg::C_A_NE_SECEND: take = stat.a_ne_secend;
            flsm_pkg::C_BOOT:        take = stat.boot;
            default:                 take = 1'b0;
        endcase

        // hold the step while the datapath waits on a handshake
        if (stat.stall)
        begin
            pc_next = pc_reg;
        end
        else if (take)
        begin
            pc_next = ucode.target;
        end
        else
        begin
            pc_next = pc_reg + 5'd1;
        end
    end

    // start in the flag clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= flsm_pkg::P_ERASE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ----- rtl/flash_log_slot_manager_top.sv -----
// Top level: log slot manager datapath, unit flag memory and stream ports.
//
//  channel | dir | tdata                                  | tuser     | tlast
//  s_*     | in  | slot, unit_valid, unit_erased,         | opcode    | scan_last
//          |     | data_same                              |           |
//  m_*     | out | dest_unit, target_sector               | command   | last_result
//
// Scan items are taken one at a time; for the item naming the first valid unit a counter
// walks up to that unit to learn its sector, and the final item ends in a load or, if no
// valid unit was seen, in erase all. A same-data save emits no change. A save searches
// unit by unit and may add a sector erase before it programs. Erase all sweeps every unit.
// After reset a clearing pass sets every flag. A result waits in one output register; the
// sequencer stalls while it waits for an input item, and when the next result finds that
// register still full.
module flash_log_slot_manager_top #(
    parameter int SECTORS          = flsm_pkg::SECTORS_DEF,
    parameter int UNITS_PER_SECTOR = flsm_pkg::UNITS_PER_SECTOR_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // slot[4:0], unit_valid, unit_erased, data_same
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    input  logic        s_tlast,   // scan_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // dest_unit[4:0], target_sector, zeros
    output logic [2:0]  m_tuser,   // command[2:0]
    output logic        m_tlast    // last_result
);

    localparam int UNITS = SECTORS * UNITS_PER_SECTOR;
    localparam int UW    = $clog2(UNITS);
    localparam int OW    = (UNITS_PER_SECTOR > 1) ? $clog2(UNITS_PER_SECTOR) : 1;
    localparam int SW    = $clog2(SECTORS);

    localparam logic [UW-1:0] LAST_UNIT = UW'(UNITS - 1);
    localparam logic [OW-1:0] LAST_OFF  = OW'(UNITS_PER_SECTOR - 1);
    localparam logic [SW-1:0] LAST_SEC  = SW'(SECTORS - 1);

    // unit index with its place inside its sector
    typedef struct packed {
        logic [UW-1:0] unit;
        logic [OW-1:0] off;
        logic [SW-1:0] sec;
    } pos_t;

    function automatic pos_t pos_inc(pos_t p);
        pos_t n;
        n.unit = (p.unit == LAST_UNIT) ? '0 : UW'(p.unit + 1'b1);
        if (p.off == LAST_OFF)
        begin
            n.off = '0;
            n.sec = (p.sec == LAST_SEC) ? '0 : SW'(p.sec + 1'b1);
        end
        else
        begin
            n.off = OW'(p.off + 1'b1);
            n.sec = p.sec;
        end
        return n;
    endfunction

    flsm_pkg::ucode_t uc;
    flsm_pkg::stat_t  stat;

    // captured input item
    logic [1:0] in_op_reg;
    logic [4:0] in_idx_reg;
    logic       in_valid_reg;
    logic       in_erased_reg;
    logic       in_last_reg;
    logic       in_same_reg;

    pos_t          t_reg, t_next;
    pos_t          cur_reg, cur_next;
    logic [UW-1:0] a_reg, a_next;
    logic [OW-1:0] a_cnt_reg, a_cnt_next;
    logic          found_reg, found_next;
    logic          took_reg, took_next;
    logic          boot_reg, boot_next;

    logic          out_valid_reg;
    flsm_pkg::cmd_t out_cmd_reg;
    logic [4:0]    out_unit_reg;
    logic          out_sec_reg;
    logic          out_last_reg;

    logic          flag_mem [UNITS];
    logic          rd_q;
    logic          wr_en;
    logic [UW-1:0] wr_addr;
    logic          wr_data;

    logic          in_accept;
    logic          in_range;
    logic          emit_go;
    logic [UW-1:0] emit_unit;
    logic [SW-1:0] emit_sec;

    flsm_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ucode (uc)
    );

    assign s_tready  = (uc.uop == flsm_pkg::U_FETCH);
    assign in_accept = s_tvalid && s_tready;
    assign in_range  = (32'(in_idx_reg) < UNITS);
    assign emit_go   = uc.emit && (!out_valid_reg || m_tready);

    always_comb
    begin
        stat.stall       = (s_tready && !s_tvalid) || (uc.emit && !emit_go);
        stat.op_scan     = (in_op_reg == flsm_pkg::OP_SCAN);
        stat.op_save     = (in_op_reg == flsm_pkg::OP_SAVE);
        stat.op_erase    = (in_op_reg == flsm_pkg::OP_ERASE_ALL);
        stat.not_took    = !took_reg;
        stat.not_last    = !in_last_reg;
        stat.not_found   = !found_reg;
        stat.same        = in_same_reg;
        stat.hit         = rd_q || (t_reg.off == '0);
        stat.erased      = rd_q;
        stat.t_ne_cur    = (t_reg.unit != cur_reg.unit);
        stat.a_ne_end    = (a_reg != LAST_UNIT);
        stat.a_ne_secend = (a_cnt_reg != LAST_OFF);
        stat.boot        = boot_reg;
    end

    always_comb
    begin
        t_next     = t_reg;
        cur_next   = cur_reg;
        a_next     = a_reg;
        a_cnt_next = a_cnt_reg;
        found_next = found_reg;
        took_next  = took_reg;
        boot_next  = boot_reg;
        wr_en      = 1'b0;
        wr_addr    = a_reg;
        wr_data    = 1'b1;

        unique case (uc.uop)
            flsm_pkg::U_NOP,
            flsm_pkg::U_FETCH:
            begin
            end
            flsm_pkg::U_SCAN_UPD:
            begin
                took_next = 1'b0;
                if (in_range)
                begin
                    wr_en   = 1'b1;
                    wr_addr = UW'(in_idx_reg);
                    wr_data = in_erased_reg;
                    if (in_valid_reg && !found_reg)
                    begin
                        cur_next.unit = UW'(in_idx_reg);
                        found_next    = 1'b1;
                        took_next     = 1'b1;
                    end
                end
            end
            flsm_pkg::U_LOC_INIT:
            begin
                t_next = '0;
            end
            flsm_pkg::U_LOC_STEP:
            begin
                // walk up to the new current unit, tracking its sector
                if (t_reg.unit != cur_reg.unit)
                begin
                    t_next = pos_inc(t_reg);
                end
            end
            flsm_pkg::U_LOC_DONE:
            begin
                cur_next.off = t_reg.off;
                cur_next.sec = t_reg.sec;
            end
            flsm_pkg::U_CLR_FOUND:
            begin
                found_next = 1'b0;
            end
            flsm_pkg::U_T_NEXT:
            begin
                t_next = pos_inc(cur_reg);
            end
            flsm_pkg::U_TINC:
            begin
                t_next = pos_inc(t_reg);
            end
            flsm_pkg::U_A_FROM_T:
            begin
                a_next     = t_reg.unit;
                a_cnt_next = '0;
            end
            flsm_pkg::U_A_CLR:
            begin
                a_next     = '0;
                a_cnt_next = '0;
            end
            flsm_pkg::U_SWEEP:
            begin
                wr_en      = 1'b1;
                wr_addr    = a_reg;
                wr_data    = 1'b1;
                a_next     = UW'(a_reg + 1'b1);
                a_cnt_next = OW'(a_cnt_reg + 1'b1);
            end
            flsm_pkg::U_WR_T0:
            begin
                wr_en   = 1'b1;
                wr_addr = t_reg.unit;
                wr_data = 1'b0;
            end
            flsm_pkg::U_WR_CUR0:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg.unit;
                wr_data = 1'b0;
            end
            flsm_pkg::U_CUR_FROM_T:
            begin
                cur_next = t_reg;
            end
            flsm_pkg::U_CUR_LAST:
            begin
                cur_next.unit = LAST_UNIT;
                cur_next.off  = LAST_OFF;
                cur_next.sec  = LAST_SEC;
                found_next    = 1'b0;
                boot_next     = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        unique case (uc.src)
            flsm_pkg::SRC_T:
            begin
                emit_unit = t_reg.unit;
                emit_sec  = t_reg.sec;
            end
            flsm_pkg::SRC_CUR:
            begin
                emit_unit = cur_reg.unit;
                emit_sec  = cur_reg.sec;
            end
            default:
            begin
                emit_unit = '0;
                emit_sec  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg         <= '0;
            cur_reg.unit  <= LAST_UNIT;
            cur_reg.off   <= LAST_OFF;
            cur_reg.sec   <= LAST_SEC;
            a_reg         <= '0;
            a_cnt_reg     <= '0;
            found_reg     <= 1'b0;
            took_reg      <= 1'b0;
            boot_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            t_reg     <= t_next;
            cur_reg   <= cur_next;
            a_reg     <= a_next;
            a_cnt_reg <= a_cnt_next;
            found_reg <= found_next;
            took_reg  <= took_next;
            boot_reg  <= boot_next;
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_op_reg     <= s_tuser;
            in_idx_reg    <= s_tdata[4:0];
            in_valid_reg  <= s_tdata[5];
            in_erased_reg <= s_tdata[6];
            in_same_reg   <= s_tdata[7];
            in_last_reg   <= s_tlast;
        end
        if (emit_go)
        begin
            out_cmd_reg  <= uc.cmd;
            out_unit_reg <= 5'(emit_unit);
            out_sec_reg  <= emit_sec[0];
            out_last_reg <= uc.last;
        end
    end

    // unit flag memory: one write port, registered read at the search pointer
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            flag_mem[wr_addr] <= wr_data;
        end
        rd_q <= flag_mem[t_reg.unit];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b0, out_sec_reg, out_unit_reg};
    assign m_tuser  = out_cmd_reg;
    assign m_tlast  = out_last_reg;

    a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg.unit <= LAST_UNIT)
        else $error("current unit beyond the ring");

    a_t_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (t_reg.unit == '0) |-> (t_reg.off == '0 && t_reg.sec == '0))
        else $error("search pointer lost its sector position");

    a_boot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        boot_reg |-> !s_tready)
        else $error("item taken during the clearing pass");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (out_cmd_reg == $past(out_cmd_reg)))
        else $error("result register overwritten while pending");

endmodule
